@@ rtl/c8alu_pkg.sv @@
// ----------------------------------------------------------------------------
// c8alu_pkg
// Operation codes, addressing modes and flag layout for the 8-bit ALU step.
// ----------------------------------------------------------------------------
package c8alu_pkg;

    localparam int unsigned OP_W   = 6;
    localparam int unsigned MODE_W = 3;
    localparam int unsigned ADDR_W = 16;
    localparam int unsigned DATA_W = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_LDA = 6'd0;
    localparam logic [OP_W-1:0] OP_LDX = 6'd1;
    localparam logic [OP_W-1:0] OP_LDY = 6'd2;
    localparam logic [OP_W-1:0] OP_STA = 6'd3;
    localparam logic [OP_W-1:0] OP_STX = 6'd4;
    localparam logic [OP_W-1:0] OP_STY = 6'd5;
    localparam logic [OP_W-1:0] OP_ADC = 6'd6;
    localparam logic [OP_W-1:0] OP_SBC = 6'd7;
    localparam logic [OP_W-1:0] OP_TAX = 6'd8;
    localparam logic [OP_W-1:0] OP_TAY = 6'd9;
    localparam logic [OP_W-1:0] OP_TSX = 6'd10;
    localparam logic [OP_W-1:0] OP_TXA = 6'd11;
    localparam logic [OP_W-1:0] OP_TXS = 6'd12;
    localparam logic [OP_W-1:0] OP_TYA = 6'd13;
    localparam logic [OP_W-1:0] OP_AND = 6'd14;
    localparam logic [OP_W-1:0] OP_ORA = 6'd15;
    localparam logic [OP_W-1:0] OP_EOR = 6'd16;
    localparam logic [OP_W-1:0] OP_ASL = 6'd17;
    localparam logic [OP_W-1:0] OP_LSR = 6'd18;
    localparam logic [OP_W-1:0] OP_INC = 6'd19;
    localparam logic [OP_W-1:0] OP_INX = 6'd20;
    localparam logic [OP_W-1:0] OP_INY = 6'd21;
    localparam logic [OP_W-1:0] OP_DEC = 6'd22;
    localparam logic [OP_W-1:0] OP_DEX = 6'd23;
    localparam logic [OP_W-1:0] OP_DEY = 6'd24;
    localparam logic [OP_W-1:0] OP_CLC = 6'd25;
    localparam logic [OP_W-1:0] OP_SEC = 6'd26;
    localparam logic [OP_W-1:0] OP_CMP = 6'd27;
    localparam logic [OP_W-1:0] OP_CPX = 6'd28;
    localparam logic [OP_W-1:0] OP_CPY = 6'd29;
    localparam logic [OP_W-1:0] OP_PHA = 6'd30;
    localparam logic [OP_W-1:0] OP_PLA = 6'd31;
    localparam logic [OP_W-1:0] OP_BIT = 6'd32;
    localparam logic [OP_W-1:0] OP_ROL = 6'd33;
    localparam logic [OP_W-1:0] OP_ROR = 6'd34;
    localparam logic [OP_W-1:0] OP_NOP = 6'd35;

    // addressing modes
    localparam logic [MODE_W-1:0] MODE_IMPL = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IMM  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ZP   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ZPX  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ZPY  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ABS  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_ABSX = 3'd6;
    localparam logic [MODE_W-1:0] MODE_ABSY = 3'd7;

    localparam logic [DATA_W-1:0] SP_RESET   = 8'hFD;
    localparam logic [DATA_W-1:0] STACK_PAGE = 8'h01;

    // bit0 carry, bit1 zero, bit2 negative
    typedef struct packed {
        logic neg;
        logic zero;
        logic carry;
    } flags_t;

endpackage

@@ rtl/cpu_8bit_alu_register_step.sv @@
// ----------------------------------------------------------------------------
// cpu_8bit_alu_register_step
// One 6502-style instruction per transaction: address, store data, registers.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one instruction per transaction (operation, addressing mode,
//   base address, operand byte already fetched by the memory side)
//   m_ channel: one result per transaction: write strobe, effective or stack
//   address, store data, A/X/Y/SP and the C/Z/N flags after the instruction
//   path: the input register loads on acceptance, the result register when
//   the instruction executes, which waits while an unread result is held;
//   the ALU, address adder and register update sit between the two
//   throughput: 1 transaction per cycle unless m_ready stalls, set by the ALU
//   and the A/X/Y/SP/flag registers, written in the same edge that loads the
//   result register so the next instruction sees them at once
//   stall: while m_valid is high and m_ready low the result and the
//   architectural registers hold; one more transaction is taken into the
//   input register, then s_ready drops until the result is taken
//   reset: aresetn low clears both valid bits and loads A=X=Y=0, SP=0xFD,
//   flags clear
// ----------------------------------------------------------------------------
module cpu_8bit_alu_register_step (
    input  logic                          aclk,
    input  logic                          aresetn,
    // instruction channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [c8alu_pkg::OP_W-1:0]    s_req_type,
    input  logic [c8alu_pkg::MODE_W-1:0]  s_addr_mode,
    input  logic [c8alu_pkg::ADDR_W-1:0]  s_base_addr,
    input  logic [c8alu_pkg::DATA_W-1:0]  s_operand,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_write_enable,
    output logic [c8alu_pkg::ADDR_W-1:0]  m_mem_addr,
    output logic [c8alu_pkg::DATA_W-1:0]  m_write_data,
    output logic [c8alu_pkg::DATA_W-1:0]  m_acc_out,
    output logic [c8alu_pkg::DATA_W-1:0]  m_x_out,
    output logic [c8alu_pkg::DATA_W-1:0]  m_y_out,
    output logic [c8alu_pkg::DATA_W-1:0]  m_sp_out,
    output logic [2:0]                    m_flags_out
);
    import c8alu_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [OP_W-1:0]   op_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [DATA_W-1:0] operand_reg;

    // architectural registers, also the register part of the result
    logic [DATA_W-1:0] a_reg,  a_next;
    logic [DATA_W-1:0] x_reg,  x_next;
    logic [DATA_W-1:0] y_reg,  y_next;
    logic [DATA_W-1:0] sp_reg, sp_next;
    flags_t            flags_reg, flags_next;

    // result register
    logic              out_valid_reg;
    logic              we_reg,   we_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [DATA_W-1:0] wd_reg,   wd_next;

    logic exec_fire;
    logic s_fire;

    // execute when an instruction waits and the result slot frees up
    assign exec_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || exec_fire;
    assign s_fire    = s_valid && s_ready;

    // execute stage
    logic              mem;
    logic [ADDR_W-1:0] eff_addr;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] sh_in;
    logic [DATA_W-1:0] sh_out;
    logic              sh_carry;
    logic [DATA_W-1:0] cmp_lhs;
    logic [DATA_W-1:0] rmw;

    always_comb begin
        mem = mode_reg inside {[MODE_ZP:MODE_ABSY]};

        case (mode_reg)
            MODE_ZP:   eff_addr = {8'h00, base_reg[7:0]};
            MODE_ZPX:  eff_addr = {8'h00, base_reg[7:0] + x_reg};
            MODE_ZPY:  eff_addr = {8'h00, base_reg[7:0] + y_reg};
            MODE_ABS:  eff_addr = base_reg;
            MODE_ABSX: eff_addr = base_reg + {8'h00, x_reg};
            MODE_ABSY: eff_addr = base_reg + {8'h00, y_reg};
            default:   eff_addr = '0;
        endcase

        // adder shared by ADC and SBC (SBC adds the inverted operand)
        sum = {1'b0, a_reg}
            + {1'b0, (op_reg == OP_SBC) ? ~operand_reg : operand_reg}
            + {{DATA_W{1'b0}}, flags_reg.carry};

        // shifter and rotator: accumulator without memory, else operand
        sh_in = mem ? operand_reg : a_reg;
        if (op_reg == OP_ASL || op_reg == OP_ROL) begin
            sh_carry = sh_in[DATA_W-1];
            sh_out   = {sh_in[DATA_W-2:0], (op_reg == OP_ROL) & flags_reg.carry};
        end else begin
            sh_carry = sh_in[0];
            sh_out   = {(op_reg == OP_ROR) & flags_reg.carry, sh_in[DATA_W-1:1]};
        end

        case (op_reg)
            OP_CPX:  cmp_lhs = x_reg;
            OP_CPY:  cmp_lhs = y_reg;
            default: cmp_lhs = a_reg;
        endcase

        rmw = (op_reg == OP_INC) ? operand_reg + 8'h01 : operand_reg - 8'h01;

        a_next     = a_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        sp_next    = sp_reg;
        flags_next = flags_reg;
        we_next    = 1'b0;
        wd_next    = '0;
        addr_next  = eff_addr;

        case (op_reg)
            OP_LDA: a_next = operand_reg;
            OP_LDX: x_next = operand_reg;
            OP_LDY: y_next = operand_reg;
            OP_STA: if (mem) begin
                we_next = 1'b1;
                wd_next = a_reg;
            end
            OP_STX: if (mem) begin
                we_next = 1'b1;
                wd_next = x_reg;
            end
            OP_STY: if (mem) begin
                we_next = 1'b1;
                wd_next = y_reg;
            end
            OP_ADC, OP_SBC: begin
                a_next           = sum[DATA_W-1:0];
                flags_next.carry = sum[DATA_W];
            end
            OP_TAX: x_next = a_reg;
            OP_TAY: y_next = a_reg;
            OP_TSX: x_next = sp_reg;
            OP_TXA: a_next = x_reg;
            OP_TXS: sp_next = x_reg;
            OP_TYA: a_next = y_reg;
            OP_AND: a_next = a_reg & operand_reg;
            OP_ORA: a_next = a_reg | operand_reg;
            OP_EOR: a_next = a_reg ^ operand_reg;
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                flags_next.carry = sh_carry;
                flags_next.zero  = (sh_out == '0);
                flags_next.neg   = sh_out[DATA_W-1];
                if (mem) begin
                    we_next = 1'b1;
                    wd_next = sh_out;
                end else begin
                    a_next = sh_out;
                end
            end
            OP_INC, OP_DEC: if (mem) begin
                flags_next.zero = (rmw == '0);
                flags_next.neg  = rmw[DATA_W-1];
                we_next         = 1'b1;
                wd_next         = rmw;
            end
            OP_INX: x_next = x_reg + 8'h01;
            OP_INY: y_next = y_reg + 8'h01;
            OP_DEX: x_next = x_reg - 8'h01;
            OP_DEY: y_next = y_reg - 8'h01;
            OP_CLC: flags_next.carry = 1'b0;
            OP_SEC: flags_next.carry = 1'b1;
            OP_CMP, OP_CPX, OP_CPY: begin
                flags_next.carry = (cmp_lhs >= operand_reg);
                flags_next.zero  = (cmp_lhs == operand_reg);
                flags_next.neg   = cmp_lhs[DATA_W-1] ^ operand_reg[DATA_W-1]
                                 ^ (cmp_lhs[DATA_W-2:0] < operand_reg[DATA_W-2:0]);
            end
            OP_PHA: begin
                addr_next = {STACK_PAGE, sp_reg};
                we_next   = 1'b1;
                wd_next   = a_reg;
                sp_next   = sp_reg - 8'h01;
            end
            OP_PLA: begin
                sp_next   = sp_reg + 8'h01;
                addr_next = {STACK_PAGE, sp_reg + 8'h01};
                a_next    = operand_reg;
            end
            OP_BIT: begin
                flags_next.zero = ((a_reg & operand_reg) == '0);
                flags_next.neg  = operand_reg[DATA_W-1];
            end
            default: ;
        endcase

        // N and Z follow the destination register whenever A, X or Y is written
        case (op_reg)
            OP_LDA, OP_ADC, OP_SBC, OP_TXA, OP_TYA, OP_AND, OP_ORA, OP_EOR,
            OP_PLA: begin
                flags_next.zero = (a_next == '0);
                flags_next.neg  = a_next[DATA_W-1];
            end
            OP_LDX, OP_TAX, OP_TSX, OP_INX, OP_DEX: begin
                flags_next.zero = (x_next == '0);
                flags_next.neg  = x_next[DATA_W-1];
            end
            OP_LDY, OP_TAY, OP_INY, OP_DEY: begin
                flags_next.zero = (y_next == '0);
                flags_next.neg  = y_next[DATA_W-1];
            end
            default: ;
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_fire) begin
            op_reg      <= s_req_type;
            mode_reg    <= s_addr_mode;
            base_reg    <= s_base_addr;
            operand_reg <= s_operand;
        end
    end

    // architectural registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            a_reg         <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            sp_reg        <= SP_RESET;
            flags_reg     <= '0;
        end else begin
            if (exec_fire) begin
                out_valid_reg <= 1'b1;
                a_reg         <= a_next;
                x_reg         <= x_next;
                y_reg         <= y_next;
                sp_reg        <= sp_next;
                flags_reg     <= flags_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (exec_fire) begin
            we_reg   <= we_next;
            addr_reg <= addr_next;
            wd_reg   <= wd_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_write_enable = we_reg;
    assign m_mem_addr     = addr_reg;
    assign m_write_data   = wd_reg;
    assign m_acc_out      = a_reg;
    assign m_x_out        = x_reg;
    assign m_y_out        = y_reg;
    assign m_sp_out       = sp_reg;
    assign m_flags_out    = flags_reg;

endmodule

@@ sim/c8alu_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c8alu_tb_pkg
// Scoreboard for the 8-bit ALU step: keeps its own copy of A, X, Y, SP and
// the C/Z/N flags, works out each instruction's result and checks the block.
// ----------------------------------------------------------------------------
package c8alu_tb_pkg;

    import c8alu_pkg::*;

    typedef struct packed {
        logic              write_en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] sp;
        flags_t            flags;
    } step_result_t;

    class c8alu_step_scoreboard;

        logic [DATA_W-1:0] reg_a;
        logic [DATA_W-1:0] reg_x;
        logic [DATA_W-1:0] reg_y;
        logic [DATA_W-1:0] reg_sp;
        logic              flag_c;
        logic              flag_z;
        logic              flag_n;
        step_result_t      expected_results[$];
        int unsigned       failures;

        function new();
            reg_a    = '0;
            reg_x    = '0;
            reg_y    = '0;
            reg_sp   = SP_RESET;
            flag_c   = 1'b0;
            flag_z   = 1'b0;
            flag_n   = 1'b0;
            failures = 0;
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction

        function void set_nz(logic [DATA_W-1:0] v);
            flag_z = (v == '0);
            flag_n = v[7];
        endfunction

        function void compare_regs(logic [DATA_W-1:0] lhs, logic [DATA_W-1:0] rhs);
            logic [DATA_W-1:0] diff;
            diff   = lhs - rhs;
            flag_c = (lhs >= rhs);
            set_nz(diff);
        endfunction

        function logic [ADDR_W-1:0] effective_addr(logic [MODE_W-1:0] mode,
                                                  logic [ADDR_W-1:0] base);
            logic [7:0] zp;
            case (mode)
                MODE_ZP:   return {8'h00, base[7:0]};
                MODE_ZPX: begin
                    zp = base[7:0] + reg_x;
                    return {8'h00, zp};
                end
                MODE_ZPY: begin
                    zp = base[7:0] + reg_y;
                    return {8'h00, zp};
                end
                MODE_ABS:  return base;
                MODE_ABSX: return base + {8'h00, reg_x};
                MODE_ABSY: return base + {8'h00, reg_y};
                default:   return '0;
            endcase
        endfunction

        // work out the result of one accepted instruction and queue it
        function void accept_instruction(logic [OP_W-1:0] op, logic [MODE_W-1:0] mode,
                                         logic [ADDR_W-1:0] base, logic [DATA_W-1:0] opnd);
            step_result_t      r;
            logic              to_mem;
            logic              cin;
            logic [8:0]        sum;
            logic [DATA_W-1:0] val;
            r      = '0;
            to_mem = (mode >= MODE_ZP);
            r.addr = effective_addr(mode, base);
            case (op)
                OP_LDA: begin reg_a = opnd; set_nz(opnd); end
                OP_LDX: begin reg_x = opnd; set_nz(opnd); end
                OP_LDY: begin reg_y = opnd; set_nz(opnd); end
                OP_STA: if (to_mem) begin r.write_en = 1'b1; r.wdata = reg_a; end
                OP_STX: if (to_mem) begin r.write_en = 1'b1; r.wdata = reg_x; end
                OP_STY: if (to_mem) begin r.write_en = 1'b1; r.wdata = reg_y; end
                OP_ADC, OP_SBC: begin
                    val    = (op == OP_SBC) ? ~opnd : opnd;
                    sum    = {1'b0, reg_a} + {1'b0, val} + {8'h00, flag_c};
                    flag_c = sum[8];
                    reg_a  = sum[7:0];
                    set_nz(reg_a);
                end
                OP_TAX: begin reg_x = reg_a;  set_nz(reg_x); end
                OP_TAY: begin reg_y = reg_a;  set_nz(reg_y); end
                OP_TSX: begin reg_x = reg_sp; set_nz(reg_x); end
                OP_TXA: begin reg_a = reg_x;  set_nz(reg_a); end
                OP_TXS: reg_sp = reg_x;
                OP_TYA: begin reg_a = reg_y;  set_nz(reg_a); end
                OP_AND: begin reg_a = reg_a & opnd; set_nz(reg_a); end
                OP_ORA: begin reg_a = reg_a | opnd; set_nz(reg_a); end
                OP_EOR: begin reg_a = reg_a ^ opnd; set_nz(reg_a); end
                OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                    val = to_mem ? opnd : reg_a;
                    cin = flag_c;
                    if (op == OP_ASL || op == OP_ROL) begin
                        flag_c = val[7];
                        val    = {val[6:0], (op == OP_ROL) ? cin : 1'b0};
                    end else begin
                        flag_c = val[0];
                        val    = {(op == OP_ROR) ? cin : 1'b0, val[7:1]};
                    end
                    set_nz(val);
                    if (to_mem) begin
                        r.write_en = 1'b1;
                        r.wdata    = val;
                    end else begin
                        reg_a = val;
                    end
                end
                OP_INC, OP_DEC: if (to_mem) begin
                    val = (op == OP_INC) ? opnd + 8'd1 : opnd - 8'd1;
                    set_nz(val);
                    r.write_en = 1'b1;
                    r.wdata    = val;
                end
                OP_INX: begin reg_x = reg_x + 8'd1; set_nz(reg_x); end
                OP_INY: begin reg_y = reg_y + 8'd1; set_nz(reg_y); end
                OP_DEX: begin reg_x = reg_x - 8'd1; set_nz(reg_x); end
                OP_DEY: begin reg_y = reg_y - 8'd1; set_nz(reg_y); end
                OP_CLC: flag_c = 1'b0;
                OP_SEC: flag_c = 1'b1;
                OP_CMP: compare_regs(reg_a, opnd);
                OP_CPX: compare_regs(reg_x, opnd);
                OP_CPY: compare_regs(reg_y, opnd);
                OP_PHA: begin
                    r.addr     = {STACK_PAGE, reg_sp};
                    r.write_en = 1'b1;
                    r.wdata    = reg_a;
                    reg_sp     = reg_sp - 8'd1;
                end
                OP_PLA: begin
                    reg_sp = reg_sp + 8'd1;
                    r.addr = {STACK_PAGE, reg_sp};
                    reg_a  = opnd;
                    set_nz(reg_a);
                end
                OP_BIT: begin
                    flag_z = ((reg_a & opnd) == '0);
                    flag_n = opnd[7];
                end
                default: ;
            endcase
            r.acc   = reg_a;
            r.x     = reg_x;
            r.y     = reg_y;
            r.sp    = reg_sp;
            r.flags = '{neg: flag_n, zero: flag_z, carry: flag_c};
            expected_results.push_back(r);
        endfunction

        function void check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic we, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata,
                                   logic [DATA_W-1:0] acc, logic [DATA_W-1:0] x,
                                   logic [DATA_W-1:0] y, logic [DATA_W-1:0] sp,
                                   logic [2:0] flags);
            step_result_t exp;
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected");
                failures++;
                return;
            end
            exp = expected_results.pop_front();
            check_field("write_enable", ADDR_W'(exp.write_en), ADDR_W'(we));
            check_field("mem_addr",     exp.addr,              addr);
            check_field("write_data",   ADDR_W'(exp.wdata),    ADDR_W'(wdata));
            check_field("acc_out",      ADDR_W'(exp.acc),      ADDR_W'(acc));
            check_field("x_out",        ADDR_W'(exp.x),        ADDR_W'(x));
            check_field("y_out",        ADDR_W'(exp.y),        ADDR_W'(y));
            check_field("sp_out",       ADDR_W'(exp.sp),       ADDR_W'(sp));
            check_field("flags_out",    ADDR_W'(exp.flags),    ADDR_W'(flags));
        endfunction

    endclass

endpackage

@@ sim/cpu_8bit_alu_register_step_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpu_8bit_alu_register_step_tb
// Drives instruction transactions into the ALU step with random gaps and
// result back-pressure, predicts every result in a scoreboard and compares
// all result fields. Directed corner instructions first, then random ones.
// ----------------------------------------------------------------------------
module cpu_8bit_alu_register_step_tb;

    import c8alu_pkg::*;
    import c8alu_tb_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 1300;
    localparam int unsigned RX_HOLD_CYCLES = 64;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned CYCLE_LIMIT    = 200000;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [OP_W-1:0]   s_req_type    = '0;
    logic [MODE_W-1:0] s_addr_mode   = '0;
    logic [ADDR_W-1:0] s_base_addr   = '0;
    logic [DATA_W-1:0] s_operand     = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic              m_write_enable;
    logic [ADDR_W-1:0] m_mem_addr;
    logic [DATA_W-1:0] m_write_data;
    logic [DATA_W-1:0] m_acc_out;
    logic [DATA_W-1:0] m_x_out;
    logic [DATA_W-1:0] m_y_out;
    logic [DATA_W-1:0] m_sp_out;
    logic [2:0]        m_flags_out;

    c8alu_step_scoreboard sb;
    int unsigned          cycles      = 0;
    bit                   tx_rush     = 1'b0;  // sender runs without gaps
    bit                   rx_hold_req = 1'b0;  // ask the result side for a long stall

    cpu_8bit_alu_register_step uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_addr_mode    (s_addr_mode),
        .s_base_addr    (s_base_addr),
        .s_operand      (s_operand),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_enable (m_write_enable),
        .m_mem_addr     (m_mem_addr),
        .m_write_data   (m_write_data),
        .m_acc_out      (m_acc_out),
        .m_x_out        (m_x_out),
        .m_y_out        (m_y_out),
        .m_sp_out       (m_sp_out),
        .m_flags_out    (m_flags_out)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // both channels are sampled at the rising edge; the stimulus moves only on
    // the falling edge, so the values seen here are the ones at the edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.accept_instruction(s_req_type, s_addr_mode, s_base_addr, s_operand);
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_write_enable, m_mem_addr, m_write_data, m_acc_out,
                            m_x_out, m_y_out, m_sp_out, m_flags_out);
        end
    end

    // offer one instruction transaction; called on a falling edge and returns
    // on the falling edge after acceptance with valid still high, so a
    // back-to-back transaction never drops valid for a step
    task automatic send_instruction(input logic [OP_W-1:0] op, input logic [MODE_W-1:0] mode,
                                    input logic [ADDR_W-1:0] base,
                                    input logic [DATA_W-1:0] opnd);
        int unsigned gap;
        gap = tx_rush ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= op;
        s_addr_mode <= mode;
        s_base_addr <= base;
        s_operand   <= opnd;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // drop valid and wait until every expected result has been taken
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);
    endtask

    // result side: random per-transaction stall, stretches with no stall,
    // and one long hold-off on request
    initial begin : result_sink
        int unsigned stall;
        int unsigned taken;
        bit          rx_rush;
        taken   = 0;
        rx_rush = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (rx_hold_req) begin
                // long hold-off counted here while the sender keeps going,
                // so the block fills and stalls its input
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
            end
            if (taken % 64 == 0) begin
                rx_rush = ($urandom_range(0, 3) == 0);
            end
            stall = rx_rush ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        logic [OP_W-1:0]   op;
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] base;
        logic [DATA_W-1:0] opnd;
        logic [DATA_W-1:0] corner_bytes[6];
        corner_bytes = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
        sb = new();

        // reset held, then released on a falling edge
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: each operation at least once, field extremes and the special cases
        send_instruction(OP_LDA, MODE_IMM,  16'h0000, 8'h00);  // zero flag
        send_instruction(OP_LDX, MODE_IMM,  16'h0000, 8'hFF);  // negative flag
        send_instruction(OP_LDY, MODE_IMPL, 16'hFFFF, 8'h80);  // implied load acts as immediate
        send_instruction(OP_STA, MODE_ZP,   16'hFFFF, 8'h00);  // zero page uses low byte only
        send_instruction(OP_STX, MODE_ZPY,  16'h00F0, 8'h00);  // zero page + Y wraps at 8 bits
        send_instruction(OP_STY, MODE_ABSX, 16'hFFFF, 8'h00);  // absolute + X wraps at 16 bits
        send_instruction(OP_STA, MODE_IMM,  16'h1234, 8'hFF);  // store without memory: no write
        send_instruction(OP_SEC, MODE_IMPL, 16'h0000, 8'h00);
        send_instruction(OP_ADC, MODE_IMM,  16'h0000, 8'hFF);  // carry in and carry out
        send_instruction(OP_SBC, MODE_ABSY, 16'hFFF0, 8'h01);
        send_instruction(OP_TAX, MODE_IMPL, 16'h0000, 8'h00);
        send_instruction(OP_TAY, MODE_ZPX,  16'h00FF, 8'h00);  // implied op still reports address
        send_instruction(OP_TSX, MODE_IMPL, 16'h0000, 8'h00);
        send_instruction(OP_TXA, MODE_IMPL, 16'h0000, 8'h00);
        send_instruction(OP_LDX, MODE_IMM,  16'h0000, 8'h00);
        send_instruction(OP_TXS, MODE_IMPL, 16'h0000, 8'h00);  // flags unchanged
        send_instruction(OP_TYA, MODE_IMPL, 16'h0000, 8'h00);
        send_instruction(OP_AND, MODE_IMM,  16'h0000, 8'hF0);
        send_instruction(OP_ORA, MODE_ZP,   16'h0012, 8'h0F);
        send_instruction(OP_EOR, MODE_ABS,  16'hFFFF, 8'hFF);
        send_instruction(OP_ASL, MODE_IMPL, 16'h0000, 8'h00);  // accumulator shift
        send_instruction(OP_LSR, MODE_IMM,  16'h0000, 8'h00);
        send_instruction(OP_ROL, MODE_ZPX,  16'h0080, 8'h80);  // memory rotate writes back
        send_instruction(OP_ROR, MODE_ABSX, 16'h8000, 8'h01);
        send_instruction(OP_INC, MODE_IMM,  16'h0000, 8'h7F);  // no memory: ignored
        send_instruction(OP_INC, MODE_ZPX,  16'h00FF, 8'hFF);
        send_instruction(OP_DEC, MODE_ABSY, 16'h0000, 8'h00);
        send_instruction(OP_INX, MODE_IMPL, 16'h0000, 8'h00);
        send_instruction(OP_INY, MODE_IMPL, 16'h0000, 8'h00);
        send_instruction(OP_DEX, MODE_IMPL, 16'h0000, 8'h00);
        send_instruction(OP_DEY, MODE_IMPL, 16'h0000, 8'h00);
        send_instruction(OP_CLC, MODE_IMPL, 16'h0000, 8'h00);
        send_instruction(OP_CMP, MODE_IMM,  16'h0000, 8'h80);
        send_instruction(OP_CPX, MODE_ZP,   16'h0000, 8'h00);
        send_instruction(OP_CPY, MODE_ABS,  16'h4000, 8'hFF);
        send_instruction(OP_PHA, MODE_ABS,  16'hBEEF, 8'h00);  // stack ignores addressing mode
        send_instruction(OP_PLA, MODE_ZP,   16'h0033, 8'h80);
        send_instruction(OP_BIT, MODE_ZP,   16'h0044, 8'hC0);  // carry unchanged
        send_instruction(OP_ROL, MODE_IMPL, 16'h0000, 8'h00);
        send_instruction(OP_ROR, MODE_IMM,  16'h0000, 8'h00);
        send_instruction(OP_NOP, MODE_ABSY, 16'h7FFF, 8'h55);
        send_instruction(6'd63,  MODE_ZPY,  16'h00AA, 8'hAA);  // unused code acts as no-op
        send_instruction(6'd36,  MODE_IMPL, 16'h0000, 8'h00);
        wait_results_drained();

        // random instructions, mostly defined operations, operand biased
        // toward the byte corners so carry/zero/negative edges come often
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) begin
                tx_rush = ($urandom_range(0, 3) == 0);
            end
            if (i == 300) begin
                tx_rush     = 1'b1;
                rx_hold_req = 1'b1;
            end
            if (i == 700) begin
                wait_results_drained();
            end
            op   = ($urandom_range(0, 9) != 0) ? OP_W'($urandom_range(0, 35))
                                               : OP_W'($urandom_range(36, 63));
            mode = MODE_W'($urandom_range(0, 7));
            base = ADDR_W'($urandom_range(0, 65535));
            opnd = ($urandom_range(0, 4) == 0) ? corner_bytes[$urandom_range(0, 5)]
                                               : DATA_W'($urandom_range(0, 255));
            send_instruction(op, mode, base, opnd);
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
